>>> rtl/adaptive_morse_timing_classifier_assert.svh
// ------------------------------------------------------------------------
// Assertion macros for the Morse timing classifier
// Clocked, reset-qualified implication forms used by the top level.
// ------------------------------------------------------------------------
`ifndef ADAPTIVE_MORSE_TIMING_CLASSIFIER_ASSERT_SVH
`define ADAPTIVE_MORSE_TIMING_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define AMTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define AMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/amtc_pkg.sv
// ------------------------------------------------------------------------
// Morse timing classifier package
// Shared types, codes and constants for the classifier and its divider.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package amtc_pkg;

    // Widths
    localparam int AVG_W = 23;
    localparam int DUR_W = 24;
    localparam int QUO_W = 21;
    localparam int ACC_W = 32;

    // Timing constants
    localparam logic [QUO_W-1:0] K_DIT_SCALE = 21'd1200000;
    localparam logic [DUR_W-1:0] K_MIN_DUR   = 24'd5000;
    localparam logic [DUR_W-1:0] K_MAX_DUR   = 24'd5000000;
    localparam logic [1:0]       K_WARMUP    = 2'd3;
    localparam logic [8:0]       K_ALPHA_ONE = 9'd256;
    localparam logic [7:0]       K_PCT       = 8'd100;

    // Configuration register indexes
    localparam logic [1:0] CFG_WPM   = 2'd0;
    localparam logic [1:0] CFG_TOL   = 2'd1;
    localparam logic [1:0] CFG_ALPHA = 2'd2;

    typedef enum logic [2:0] {
        EV_UNKNOWN = 3'd0,
        EV_DIT     = 3'd1,
        EV_DAH     = 3'd2,
        EV_INTRA   = 3'd3,
        EV_CHAR    = 3'd4,
        EV_WORD    = 3'd5
    } t_event;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RST_DIV,
        ST_RST_WAIT,
        ST_RST_DAH,
        ST_MK_DIT3,
        ST_MK_BASE,
        ST_MK_THR,
        ST_MK_DUR,
        ST_MK_CMP,
        ST_MK_NEW,
        ST_MK_OLD,
        ST_MK_UPD,
        ST_SP_DIT2,
        ST_SP_DIT5,
        ST_SP_CMP,
        ST_SPEED,
        ST_SPD_WAIT,
        ST_OUT
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [AVG_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/amtc_div.sv
// ------------------------------------------------------------------------
// Serial divider
// Restoring shift-subtract divider, 1200000 by a 23-bit divisor,
// one quotient bit per cycle, done pulse after the last bit.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module amtc_div
    import amtc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [AVG_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [AVG_W-1:0] r_dvs;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [AVG_W:0]   w_sh;
    logic [AVG_W:0]   w_diff;
    logic             w_ge;

    // Trial subtract of the shifted remainder
    assign w_sh   = {r_rem, r_quo[QUO_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_diff = w_sh - {1'b0, r_dvs};

    // Control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift one quotient bit in per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= K_DIT_SCALE;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[AVG_W-1:0] : w_sh[AVG_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> rtl/adaptive_morse_timing_classifier.sv
// ------------------------------------------------------------------------
// Adaptive Morse timing classifier
// Classifies keyed intervals as dit, dah or gap against running averages,
// tracks the averages by moving average and reports speed and warm-up.
// ------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------
//  input   | in        | i_valid / o_stall        | req_type, interval_us, is_mark
//  result  | out       | o_valid / i_stall        | event_res, speed_wpm, calibrated
//  config  | in        | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data
//
//  Each accepted word runs through the sequencer states for a mark, a space,
//  a restart or an out-of-range interval; the serial divider for the speed
//  (with its start and wait states) and the one shared 25x9 multiplier are
//  stepped by the sequencer. While warming up the speed division is skipped;
//  a restart never divides for speed. Synchronous active-low reset restores
//  averages, warm-up, configuration, state and the output valid flag.
//  o_stall is high while a word is in work; the next word can be taken in the
//  cycle after the result is loaded, and a stalled result waits in the output
//  register while the next word is taken.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_morse_timing_classifier
    import amtc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input words
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_req_type,
    input  logic [DUR_W-1:0] i_interval_us,
    input  logic             i_is_mark,
    // result words
    output logic             o_valid,
    input  logic             i_stall,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_speed_wpm,
    output logic             o_calibrated,
    // configuration writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [8:0]       i_cfg_data
);

    t_state           r_state, n_state;
    logic             r_req, n_req;
    logic [DUR_W-1:0] r_dur, n_dur;
    logic             r_mark, n_mark;
    logic [ACC_W-1:0] r_t, n_t;
    logic [ACC_W-1:0] r_u, n_u;
    t_event           r_ev, n_ev;
    logic [7:0]       r_spd, n_spd;
    logic [AVG_W-1:0] r_dit, n_dit;
    logic [AVG_W-1:0] r_dah, n_dah;
    logic [1:0]       r_warm, n_warm;
    logic [6:0]       r_wpm, n_wpm;
    logic [6:0]       r_tol, n_tol;
    logic [8:0]       r_alpha, n_alpha;
    logic             r_out_valid, n_out_valid;
    t_event           r_out_ev, n_out_ev;
    logic [7:0]       r_out_spd, n_out_spd;
    logic             r_out_cal, n_out_cal;

    logic [24:0]      mul_a;
    logic [8:0]       mul_b;
    logic [33:0]      mul_p;
    logic [8:0]       w_alpha;
    logic [6:0]       w_wpm;
    logic [ACC_W:0]   w_sum;
    logic [AVG_W-1:0] w_new;
    logic             w_accept;
    logic             w_div_wait;
    logic             w_warm_step;
    logic             w_out_idle;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    // Shared speed and restart divider
    amtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Shared multiplier
    assign mul_p = {9'b0, mul_a} * {25'b0, mul_b};

    // Saturated weight, clamped start speed, moving-average sum
    assign w_alpha  = (r_alpha > K_ALPHA_ONE) ? K_ALPHA_ONE : r_alpha;
    assign w_wpm    = (r_wpm == 7'd0) ? 7'd1 : r_wpm;
    assign w_sum    = {1'b0, r_t} + {1'b0, r_u};
    assign w_new    = w_sum[AVG_W+7:8];
    assign w_accept = i_valid && !o_stall;

    // Sequencer: next state, datapath updates, multiplier and divider control
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_dur       = r_dur;
        n_mark      = r_mark;
        n_t         = r_t;
        n_u         = r_u;
        n_ev        = r_ev;
        n_spd       = r_spd;
        n_dit       = r_dit;
        n_dah       = r_dah;
        n_warm      = r_warm;
        n_wpm       = r_wpm;
        n_tol       = r_tol;
        n_alpha     = r_alpha;
        n_out_valid = r_out_valid;
        n_out_ev    = r_out_ev;
        n_out_spd   = r_out_spd;
        n_out_cal   = r_out_cal;
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;

        // take configuration writes
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WPM:   n_wpm   = i_cfg_data[6:0];
                CFG_TOL:   n_tol   = i_cfg_data[6:0];
                CFG_ALPHA: n_alpha = i_cfg_data;
                default:   ;
            endcase
        end

        // drop the result word once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_req   = i_req_type;
                    n_dur   = i_interval_us;
                    n_mark  = i_is_mark;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (r_req) begin
                    n_state = ST_RST_DIV;
                end else if (r_dur < K_MIN_DUR || r_dur > K_MAX_DUR) begin
                    n_ev    = EV_UNKNOWN;
                    n_state = ST_SPEED;
                end else if (r_mark) begin
                    n_state = ST_MK_DIT3;
                end else begin
                    n_state = ST_SP_DIT2;
                end
            end
            // restart: dit from start speed, dah three times that
            ST_RST_DIV: begin
                div_req.start   = 1'b1;
                div_req.divisor = {16'b0, w_wpm};
                n_state         = ST_RST_WAIT;
            end
            ST_RST_WAIT: begin
                if (div_rsp.done) begin
                    n_dit   = {2'b0, div_rsp.quot};
                    n_state = ST_RST_DAH;
                end
            end
            ST_RST_DAH: begin
                mul_a   = {2'b0, r_dit};
                mul_b   = 9'd3;
                n_dah   = mul_p[AVG_W-1:0];
                n_warm  = K_WARMUP;
                n_ev    = EV_UNKNOWN;
                n_state = ST_SPEED;
            end
            // mark: threshold base*(100+tol)/100, tested as 100*(dur+1) <= product
            ST_MK_DIT3: begin
                mul_a   = {2'b0, r_dit};
                mul_b   = 9'd3;
                n_t     = mul_p[ACC_W-1:0];
                n_state = ST_MK_BASE;
            end
            ST_MK_BASE: begin
                n_t     = 32'({r_t[25:0] + {3'b0, r_dah}} >> 2);
                n_state = ST_MK_THR;
            end
            ST_MK_THR: begin
                mul_a   = {2'b0, r_t[AVG_W-1:0]};
                mul_b   = {1'b0, 8'(K_PCT + {1'b0, r_tol})};
                n_t     = mul_p[ACC_W-1:0];
                n_state = ST_MK_DUR;
            end
            ST_MK_DUR: begin
                mul_a   = {1'b0, r_dur} + 25'd1;
                mul_b   = {1'b0, K_PCT};
                n_u     = mul_p[ACC_W-1:0];
                n_state = ST_MK_CMP;
            end
            ST_MK_CMP: begin
                n_ev    = (r_u <= r_t) ? EV_DIT : EV_DAH;
                n_state = ST_MK_NEW;
            end
            ST_MK_NEW: begin
                mul_a   = {1'b0, r_dur};
                mul_b   = w_alpha;
                n_t     = mul_p[ACC_W-1:0];
                n_state = ST_MK_OLD;
            end
            ST_MK_OLD: begin
                mul_a   = {2'b0, (r_ev == EV_DIT) ? r_dit : r_dah};
                mul_b   = K_ALPHA_ONE - w_alpha;
                n_u     = mul_p[ACC_W-1:0];
                n_state = ST_MK_UPD;
            end
            ST_MK_UPD: begin
                if (r_ev == EV_DIT) begin
                    n_dit = w_new;
                end else begin
                    n_dah = w_new;
                end
                if (r_warm != 2'd0) begin
                    n_warm = r_warm - 2'd1;
                end
                n_state = ST_SPEED;
            end
            // space: compare against two and five dits
            ST_SP_DIT2: begin
                mul_a   = {2'b0, r_dit};
                mul_b   = 9'd2;
                n_t     = mul_p[ACC_W-1:0];
                n_state = ST_SP_DIT5;
            end
            ST_SP_DIT5: begin
                mul_a   = {2'b0, r_dit};
                mul_b   = 9'd5;
                n_u     = mul_p[ACC_W-1:0];
                n_state = ST_SP_CMP;
            end
            ST_SP_CMP: begin
                if ({8'b0, r_dur} < r_t) begin
                    n_ev = EV_INTRA;
                end else if ({8'b0, r_dur} < r_u) begin
                    n_ev = EV_CHAR;
                end else begin
                    n_ev = EV_WORD;
                end
                n_state = ST_SPEED;
            end
            // speed from the updated state, zero while warming up or with a zero dit average
            ST_SPEED: begin
                if (r_warm == 2'd0 && r_dit != '0) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = r_dit;
                    n_state         = ST_SPD_WAIT;
                end else begin
                    n_spd   = 8'd0;
                    n_state = ST_OUT;
                end
            end
            ST_SPD_WAIT: begin
                if (div_rsp.done) begin
                    n_spd   = (div_rsp.quot[QUO_W-1:8] != '0) ? 8'd255
                                                              : div_rsp.quot[7:0];
                    n_state = ST_OUT;
                end
            end
            // hand the word to the output register once it is free
            ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_ev    = r_ev;
                    n_out_spd   = r_spd;
                    n_out_cal   = (r_warm == 2'd0);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control, calibration state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit       <= 23'd60000;
            r_dah       <= 23'd180000;
            r_warm      <= K_WARMUP;
            r_wpm       <= 7'd20;
            r_tol       <= 7'd25;
            r_alpha     <= 9'd77;
            r_out_valid <= 1'b0;
        end else begin
            r_dit       <= n_dit;
            r_dah       <= n_dah;
            r_warm      <= n_warm;
            r_wpm       <= n_wpm;
            r_tol       <= n_tol;
            r_alpha     <= n_alpha;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_dur     <= n_dur;
        r_mark    <= n_mark;
        r_t       <= n_t;
        r_u       <= n_u;
        r_ev      <= n_ev;
        r_spd     <= n_spd;
        r_out_ev  <= n_out_ev;
        r_out_spd <= n_out_spd;
        r_out_cal <= n_out_cal;
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_valid;
    assign o_event_res  = r_out_ev;
    assign o_speed_wpm  = r_out_spd;
    assign o_calibrated = r_out_cal;

    // Assertion terms
    assign w_div_wait  = (r_state == ST_RST_WAIT || r_state == ST_SPD_WAIT);
    assign w_warm_step = (r_state == ST_MK_UPD && r_warm != 2'd0);
    assign w_out_idle  = (r_state != ST_OUT && !o_valid);

`include "adaptive_morse_timing_classifier_assert.svh"

    `AMTC_ASSERT_NOW(a_div_done_waited, div_rsp.done, w_div_wait, "divider done outside a wait")
    `AMTC_ASSERT_NEXT(a_warm_step, w_warm_step, r_warm == $past(r_warm) - 2'd1, "no warm-up step")
    `AMTC_ASSERT_NEXT(a_out_from_seq, w_out_idle, !o_valid, "result raised outside output step")

endmodule
